// ===== rtl/core/swr_pm_pkg.sv =====
// Shared types, widths and constants of the SWR power meter.
package swr_pm_pkg;

    localparam int SAMPLE_BITS_DEF = 10;

    localparam int ACC_W   = 16;
    localparam int CNT_W   = 7;
    localparam int AVG_W   = 16;
    localparam int POW_W   = 16;
    localparam int SWR_W   = 10;
    localparam int FLOOR_W = 10;
    localparam int REF_W   = 16;
    localparam int CAL_W   = 10;

    localparam int SQ_W  = 2 * AVG_W;
    localparam int NUM_W = SQ_W + REF_W;
    localparam int DEN_W = 2 * CAL_W;

    localparam int SWR_NUM_W  = 24;
    localparam int SWR_DK_W   = 26;
    localparam int SWR_Q_BITS = 10;

    localparam int DIV_REM_W  = DEN_W;
    localparam int DIV_LOW_W  = 16;
    localparam int DIV_STEP_W = 5;

    localparam logic [DIV_STEP_W-1:0] STEPS_FULL = DIV_STEP_W'(DIV_LOW_W);
    localparam logic [DIV_STEP_W-1:0] STEPS_SWR  = DIV_STEP_W'(SWR_Q_BITS);

    localparam logic [CNT_W-1:0] COUNT_MAX   = 7'd64;
    localparam logic [SWR_W-1:0] SWR_INVALID = 10'd999;
    localparam logic [SWR_W-1:0] SWR_MATCHED = 10'd100;
    localparam logic [POW_W-1:0] POWER_MAX   = 16'hFFFF;
    localparam logic [SWR_NUM_W-1:0] SWR_SCALE = 24'd100;
    localparam logic [SWR_DK_W-1:0]  SWR_LIMIT = 26'd1000;

    localparam logic [CNT_W-1:0]   RST_SAMPLE_COUNT = 7'd8;
    localparam logic [FLOOR_W-1:0] RST_NOISE_FLOOR  = 10'd10;
    localparam logic [REF_W-1:0]   RST_REF_POWER    = 16'd5000;
    localparam logic [CAL_W-1:0]   RST_CAL_READING  = 10'd512;

    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 16;

    localparam int OUT_FIELDS_W = 2 * POW_W + SWR_W;
    localparam int OUT_W        = ((OUT_FIELDS_W + 7) / 8) * 8;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_SAMPLE_COUNT,
        CFG_NOISE_FLOOR,
        CFG_REF_POWER,
        CFG_CAL_READING
    } cfg_idx_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_AVG_F,
        ST_AVG_F_WAIT,
        ST_AVG_R,
        ST_AVG_R_WAIT,
        ST_SQ,
        ST_MUL,
        ST_PWR,
        ST_PWR_WAIT,
        ST_SWR_PREP,
        ST_SWR,
        ST_SWR_WAIT,
        ST_OUT
    } state_t;

    typedef enum logic [1:0] {
        DOP_AVG_F,
        DOP_AVG_R,
        DOP_PWR,
        DOP_SWR
    } div_op_t;

    typedef struct packed {
        logic    accept;
        logic    clear_accum;
        logic    div_start;
        div_op_t div_op;
        logic    chan;
        logic    store_avg_f;
        logic    store_avg_r;
        logic    load_sq;
        logic    load_num;
        logic    store_pwr;
        logic    load_swr;
        logic    store_swr;
        logic    load_out;
    } dp_cmd_t;

    typedef struct packed {
        logic meas_done;
        logic pwr_skip;
        logic swr_skip;
        logic div_done;
    } dp_status_t;

endpackage

// ===== rtl/core/swr_power_meter_core.sv =====
// Top level of the SWR power meter: sample averaging, power and SWR.
//
//  port group   dir  word contents
//  s_*          in   fwd_sample, rev_sample (SAMPLE_BITS each)
//  m_*          out  forward mW (16), reflected mW (16), swr_hundredths (10)
//  cfg_*        in   sample_count, noise_floor, ref_power_mw, cal_reading
//
// A word that only adds to the sums is taken without holding s_tready low.
// The word that completes a measurement holds s_tready low after it is taken, while
// five quotients (two averages, two powers, SWR) go through one shared bit-serial
// divider; special cases (below floor, saturation, invalid SWR) skip power or SWR divisions.
// Reset (synchronous, active low) restores the register defaults and clears the sums.
// A result waiting on m_tready does not block new words until the next one completes.
module swr_power_meter_core #(
    parameter int SAMPLE_BITS = swr_pm_pkg::SAMPLE_BITS_DEF
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    // fwd_sample [SAMPLE_BITS-1:0], rev_sample above it, zero padded
    input  logic [((2*SAMPLE_BITS+7)/8)*8-1:0]    s_tdata,
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    // forward mW [15:0], reflected mW [31:16], swr_hundredths [41:32], zero padded
    output logic [swr_pm_pkg::OUT_W-1:0]          m_tdata,
    input  logic                                  cfg_we,
    input  logic [swr_pm_pkg::CFG_ADDR_W-1:0]     cfg_addr,
    input  logic [swr_pm_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

    localparam int POW_W = swr_pm_pkg::POW_W;
    localparam int SWR_W = swr_pm_pkg::SWR_W;
    localparam int PAD_W = swr_pm_pkg::OUT_W - swr_pm_pkg::OUT_FIELDS_W;

    swr_pm_pkg::dp_cmd_t    cmd;
    swr_pm_pkg::dp_status_t status;

    logic [POW_W-1:0] fwd_mw;
    logic [POW_W-1:0] rev_mw;
    logic [SWR_W-1:0] swr_hundredths;

    swr_pm_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    swr_pm_datapath #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_we         (cfg_we),
        .cfg_addr       (cfg_addr),
        .cfg_wdata      (cfg_wdata),
        .fwd_sample     (s_tdata[SAMPLE_BITS-1:0]),
        .rev_sample     (s_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS]),
        .cmd            (cmd),
        .status         (status),
        .fwd_mw         (fwd_mw),
        .rev_mw         (rev_mw),
        .swr_hundredths (swr_hundredths)
    );

    assign m_tdata = {{PAD_W{1'b0}}, swr_hundredths, rev_mw, fwd_mw};

endmodule

// ===== rtl/core/swr_pm_div.sv =====
// Iterative restoring divider, one quotient bit per cycle.
module swr_pm_div (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                start,
    input  logic [swr_pm_pkg::DIV_REM_W-1:0]    rem_init,
    input  logic [swr_pm_pkg::DIV_LOW_W-1:0]    low_init,
    input  logic [swr_pm_pkg::DIV_REM_W-1:0]    divisor,
    input  logic [swr_pm_pkg::DIV_STEP_W-1:0]   steps,
    output logic                                done,
    output logic [swr_pm_pkg::DIV_LOW_W-1:0]    quotient
);

    localparam int RW = swr_pm_pkg::DIV_REM_W;
    localparam int LW = swr_pm_pkg::DIV_LOW_W;
    localparam int SW = swr_pm_pkg::DIV_STEP_W;

    logic [RW-1:0] rem_reg, rem_next;
    logic [LW-1:0] low_reg, low_next;
    logic [LW-1:0] q_reg, q_next;
    logic [RW-1:0] div_reg, div_next;
    logic [SW-1:0] cnt_reg, cnt_next;
    logic          busy_reg, busy_next;
    logic          done_reg, done_next;

    logic [RW:0] trial;
    logic [RW:0] diff;
    logic        ge;

    always_comb begin
        trial = {rem_reg, low_reg[LW-1]};
        diff  = trial - {1'b0, div_reg};
        ge    = trial >= {1'b0, div_reg};
    end

    always_comb begin
        rem_next  = rem_reg;
        low_next  = low_reg;
        q_next    = q_reg;
        div_next  = div_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            rem_next  = rem_init;
            low_next  = low_init;
            q_next    = '0;
            div_next  = divisor;
            cnt_next  = steps;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            // shift in the next dividend bit, subtract when it fits
            rem_next = ge ? diff[RW-1:0] : trial[RW-1:0];
            low_next = {low_reg[LW-2:0], 1'b0};
            q_next   = {q_reg[LW-2:0], ge};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == SW'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        low_reg <= low_next;
        q_reg   <= q_next;
        div_reg <= div_next;
    end

    assign done     = done_reg;
    assign quotient = q_reg;

endmodule

// ===== rtl/core/swr_pm_datapath.sv =====
// Datapath: configuration, sums, averages, power and SWR arithmetic.
module swr_pm_datapath #(
    parameter int SAMPLE_BITS = swr_pm_pkg::SAMPLE_BITS_DEF
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 cfg_we,
    input  logic [swr_pm_pkg::CFG_ADDR_W-1:0]    cfg_addr,
    input  logic [swr_pm_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    input  logic [SAMPLE_BITS-1:0]               fwd_sample,
    input  logic [SAMPLE_BITS-1:0]               rev_sample,
    input  swr_pm_pkg::dp_cmd_t                  cmd,
    output swr_pm_pkg::dp_status_t               status,
    output logic [swr_pm_pkg::POW_W-1:0]         fwd_mw,
    output logic [swr_pm_pkg::POW_W-1:0]         rev_mw,
    output logic [swr_pm_pkg::SWR_W-1:0]         swr_hundredths
);

    localparam int ACC_W   = swr_pm_pkg::ACC_W;
    localparam int CNT_W   = swr_pm_pkg::CNT_W;
    localparam int AVG_W   = swr_pm_pkg::AVG_W;
    localparam int POW_W   = swr_pm_pkg::POW_W;
    localparam int SWR_W   = swr_pm_pkg::SWR_W;
    localparam int FLOOR_W = swr_pm_pkg::FLOOR_W;
    localparam int REF_W   = swr_pm_pkg::REF_W;
    localparam int CAL_W   = swr_pm_pkg::CAL_W;
    localparam int SQ_W    = swr_pm_pkg::SQ_W;
    localparam int NUM_W   = swr_pm_pkg::NUM_W;
    localparam int DEN_W   = swr_pm_pkg::DEN_W;
    localparam int SN_W    = swr_pm_pkg::SWR_NUM_W;
    localparam int SK_W    = swr_pm_pkg::SWR_DK_W;
    localparam int SQB     = swr_pm_pkg::SWR_Q_BITS;
    localparam int RW      = swr_pm_pkg::DIV_REM_W;
    localparam int LW      = swr_pm_pkg::DIV_LOW_W;
    localparam int SW      = swr_pm_pkg::DIV_STEP_W;

    // configuration
    logic [CNT_W-1:0]   sample_count_reg, sample_count_next;
    logic [FLOOR_W-1:0] noise_floor_reg, noise_floor_next;
    logic [REF_W-1:0]   ref_power_reg, ref_power_next;
    logic [CAL_W-1:0]   cal_reading_reg, cal_reading_next;

    // accumulation
    logic [ACC_W-1:0] fwd_accum_reg, fwd_accum_next;
    logic [ACC_W-1:0] rev_accum_reg, rev_accum_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] count_plus;
    logic [CNT_W-1:0] n_eff;

    // arithmetic
    logic [AVG_W-1:0] favg_reg, favg_next;
    logic [AVG_W-1:0] ravg_reg, ravg_next;
    logic [SQ_W-1:0]  sq_reg, sq_next;
    logic [DEN_W-1:0] den_reg, den_next;
    logic [NUM_W-1:0] num_reg, num_next;
    logic [POW_W-1:0] fpow_reg, fpow_next;
    logic [POW_W-1:0] rpow_reg, rpow_next;
    logic [SN_W-1:0]  swr_num_reg, swr_num_next;
    logic [AVG_W-1:0] swr_d_reg, swr_d_next;
    logic [SK_W-1:0]  swr_dk_reg, swr_dk_next;
    logic [SWR_W-1:0] swr_reg, swr_next;

    logic [POW_W-1:0] out_fpow_reg, out_fpow_next;
    logic [POW_W-1:0] out_rpow_reg, out_rpow_next;
    logic [SWR_W-1:0] out_swr_reg, out_swr_next;

    logic [AVG_W-1:0] avg_sel;
    logic [AVG_W-1:0] floor_ext;
    logic [AVG_W:0]   sum_fr;
    logic [AVG_W-1:0] diff_fr;
    logic             pwr_below;
    logic             pwr_sat;
    logic [POW_W-1:0] pwr_value;
    logic             f_low;
    logic             r_low;
    logic             f_le_r;
    logic             swr_sat;
    logic [SWR_W-1:0] swr_q;
    logic [SWR_W-1:0] swr_value;

    // divider hookup
    logic [RW-1:0] div_rem;
    logic [LW-1:0] div_low;
    logic [RW-1:0] div_divisor;
    logic [SW-1:0] div_steps;
    logic          div_done;
    logic [LW-1:0] div_q;

    swr_pm_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_start),
        .rem_init (div_rem),
        .low_init (div_low),
        .divisor  (div_divisor),
        .steps    (div_steps),
        .done     (div_done),
        .quotient (div_q)
    );

    always_comb begin
        sample_count_next = sample_count_reg;
        noise_floor_next  = noise_floor_reg;
        ref_power_next    = ref_power_reg;
        cal_reading_next  = cal_reading_reg;
        if (cfg_we) begin
            case (swr_pm_pkg::cfg_idx_t'(cfg_addr))
                swr_pm_pkg::CFG_SAMPLE_COUNT: sample_count_next = cfg_wdata[CNT_W-1:0];
                swr_pm_pkg::CFG_NOISE_FLOOR:  noise_floor_next  = cfg_wdata[FLOOR_W-1:0];
                swr_pm_pkg::CFG_REF_POWER:    ref_power_next    = cfg_wdata[REF_W-1:0];
                swr_pm_pkg::CFG_CAL_READING:  cal_reading_next  = cfg_wdata[CAL_W-1:0];
                default: ;
            endcase
        end
    end

    // clamp the pair count to 1..64
    always_comb begin
        if (sample_count_reg == '0) begin
            n_eff = CNT_W'(1);
        end else if (sample_count_reg > swr_pm_pkg::COUNT_MAX) begin
            n_eff = swr_pm_pkg::COUNT_MAX;
        end else begin
            n_eff = sample_count_reg;
        end
    end

    always_comb begin
        count_plus     = count_reg + 1'b1;
        fwd_accum_next = fwd_accum_reg;
        rev_accum_next = rev_accum_reg;
        count_next     = count_reg;
        if (cmd.clear_accum) begin
            fwd_accum_next = '0;
            rev_accum_next = '0;
            count_next     = '0;
        end else if (cmd.accept) begin
            fwd_accum_next = fwd_accum_reg + {{(ACC_W-SAMPLE_BITS){1'b0}}, fwd_sample};
            rev_accum_next = rev_accum_reg + {{(ACC_W-SAMPLE_BITS){1'b0}}, rev_sample};
            count_next     = count_plus;
        end
    end

    always_comb begin
        case (cmd.div_op)
            swr_pm_pkg::DOP_AVG_F: begin
                div_rem     = '0;
                div_low     = fwd_accum_reg;
                div_divisor = {{(RW-CNT_W){1'b0}}, n_eff};
                div_steps   = swr_pm_pkg::STEPS_FULL;
            end
            swr_pm_pkg::DOP_AVG_R: begin
                div_rem     = '0;
                div_low     = rev_accum_reg;
                div_divisor = {{(RW-CNT_W){1'b0}}, n_eff};
                div_steps   = swr_pm_pkg::STEPS_FULL;
            end
            swr_pm_pkg::DOP_PWR: begin
                // upper part is below the divisor once saturation is ruled out
                div_rem     = num_reg[LW +: RW];
                div_low     = num_reg[LW-1:0];
                div_divisor = den_reg;
                div_steps   = swr_pm_pkg::STEPS_FULL;
            end
            swr_pm_pkg::DOP_SWR: begin
                div_rem     = {{(RW-(SN_W-SQB)){1'b0}}, swr_num_reg[SN_W-1:SQB]};
                div_low     = {swr_num_reg[SQB-1:0], {(LW-SQB){1'b0}}};
                div_divisor = {{(RW-AVG_W){1'b0}}, swr_d_reg};
                div_steps   = swr_pm_pkg::STEPS_SWR;
            end
            default: begin
                div_rem     = '0;
                div_low     = fwd_accum_reg;
                div_divisor = {{(RW-CNT_W){1'b0}}, n_eff};
                div_steps   = swr_pm_pkg::STEPS_FULL;
            end
        endcase
    end

    // power of the selected channel
    always_comb begin
        avg_sel   = cmd.chan ? ravg_reg : favg_reg;
        floor_ext = {{(AVG_W-FLOOR_W){1'b0}}, noise_floor_reg};
        pwr_below = avg_sel < floor_ext;
        pwr_sat   = num_reg >= {{(NUM_W-DEN_W-LW){1'b0}}, den_reg, {LW{1'b0}}};
        if (pwr_below) begin
            pwr_value = '0;
        end else if (pwr_sat) begin
            pwr_value = swr_pm_pkg::POWER_MAX;
        end else begin
            pwr_value = div_q[POW_W-1:0];
        end
    end

    // SWR special cases and clamp
    always_comb begin
        sum_fr  = {1'b0, favg_reg} + {1'b0, ravg_reg};
        diff_fr = favg_reg - ravg_reg;
        f_low   = favg_reg < floor_ext;
        r_low   = ravg_reg < floor_ext;
        f_le_r  = favg_reg <= ravg_reg;
        swr_sat = {{(SK_W-SN_W){1'b0}}, swr_num_reg} >= swr_dk_reg;
        swr_q   = div_q[SWR_W-1:0];
        if (f_low) begin
            swr_value = swr_pm_pkg::SWR_INVALID;
        end else if (r_low) begin
            swr_value = swr_pm_pkg::SWR_MATCHED;
        end else if (f_le_r || swr_sat) begin
            swr_value = swr_pm_pkg::SWR_INVALID;
        end else if (swr_q < swr_pm_pkg::SWR_MATCHED) begin
            swr_value = swr_pm_pkg::SWR_MATCHED;
        end else begin
            swr_value = swr_q;
        end
    end

    always_comb begin
        favg_next     = cmd.store_avg_f ? div_q[AVG_W-1:0] : favg_reg;
        ravg_next     = cmd.store_avg_r ? div_q[AVG_W-1:0] : ravg_reg;
        sq_next       = sq_reg;
        den_next      = den_reg;
        num_next      = num_reg;
        fpow_next     = fpow_reg;
        rpow_next     = rpow_reg;
        swr_num_next  = swr_num_reg;
        swr_d_next    = swr_d_reg;
        swr_dk_next   = swr_dk_reg;
        swr_next      = swr_reg;
        out_fpow_next = out_fpow_reg;
        out_rpow_next = out_rpow_reg;
        out_swr_next  = out_swr_reg;
        if (cmd.load_sq) begin
            sq_next  = {{(SQ_W-AVG_W){1'b0}}, avg_sel} * {{(SQ_W-AVG_W){1'b0}}, avg_sel};
            den_next = {{(DEN_W-CAL_W){1'b0}}, cal_reading_reg}
                     * {{(DEN_W-CAL_W){1'b0}}, cal_reading_reg};
        end
        if (cmd.load_num) begin
            num_next = {{(NUM_W-SQ_W){1'b0}}, sq_reg} * {{(NUM_W-REF_W){1'b0}}, ref_power_reg};
        end
        if (cmd.store_pwr) begin
            if (cmd.chan) begin
                rpow_next = pwr_value;
            end else begin
                fpow_next = pwr_value;
            end
        end
        if (cmd.load_swr) begin
            swr_num_next = {{(SN_W-AVG_W-1){1'b0}}, sum_fr} * swr_pm_pkg::SWR_SCALE;
            swr_d_next   = diff_fr;
            swr_dk_next  = {{(SK_W-AVG_W){1'b0}}, diff_fr} * swr_pm_pkg::SWR_LIMIT;
        end
        if (cmd.store_swr) begin
            swr_next = swr_value;
        end
        if (cmd.load_out) begin
            out_fpow_next = fpow_reg;
            out_rpow_next = rpow_reg;
            out_swr_next  = swr_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sample_count_reg <= swr_pm_pkg::RST_SAMPLE_COUNT;
            noise_floor_reg  <= swr_pm_pkg::RST_NOISE_FLOOR;
            ref_power_reg    <= swr_pm_pkg::RST_REF_POWER;
            cal_reading_reg  <= swr_pm_pkg::RST_CAL_READING;
            fwd_accum_reg    <= '0;
            rev_accum_reg    <= '0;
            count_reg        <= '0;
        end else begin
            sample_count_reg <= sample_count_next;
            noise_floor_reg  <= noise_floor_next;
            ref_power_reg    <= ref_power_next;
            cal_reading_reg  <= cal_reading_next;
            fwd_accum_reg    <= fwd_accum_next;
            rev_accum_reg    <= rev_accum_next;
            count_reg        <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        favg_reg     <= favg_next;
        ravg_reg     <= ravg_next;
        sq_reg       <= sq_next;
        den_reg      <= den_next;
        num_reg      <= num_next;
        fpow_reg     <= fpow_next;
        rpow_reg     <= rpow_next;
        swr_num_reg  <= swr_num_next;
        swr_d_reg    <= swr_d_next;
        swr_dk_reg   <= swr_dk_next;
        swr_reg      <= swr_next;
        out_fpow_reg <= out_fpow_next;
        out_rpow_reg <= out_rpow_next;
        out_swr_reg  <= out_swr_next;
    end

    always_comb begin
        status.meas_done = count_plus >= n_eff;
        status.pwr_skip  = pwr_below || pwr_sat;
        status.swr_skip  = f_low || r_low || f_le_r || swr_sat;
        status.div_done  = div_done;
    end

    assign fwd_mw         = out_fpow_reg;
    assign rev_mw         = out_rpow_reg;
    assign swr_hundredths = out_swr_reg;

endmodule

// ===== rtl/core/swr_pm_ctrl.sv =====
// Controller: sequences accumulation, divisions and result hand-off.
module swr_pm_ctrl (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_tvalid,
    output logic                    s_tready,
    output logic                    m_tvalid,
    input  logic                    m_tready,
    input  swr_pm_pkg::dp_status_t  status,
    output swr_pm_pkg::dp_cmd_t     cmd
);

    swr_pm_pkg::state_t state_reg, state_next;
    logic               chan_reg, chan_next;
    logic               out_valid_reg, out_valid_next;

    always_comb begin
        state_next = state_reg;
        chan_next  = chan_reg;
        case (state_reg)
            swr_pm_pkg::ST_IDLE: begin
                if (s_tvalid && status.meas_done) begin
                    state_next = swr_pm_pkg::ST_AVG_F;
                end
            end
            swr_pm_pkg::ST_AVG_F: state_next = swr_pm_pkg::ST_AVG_F_WAIT;
            swr_pm_pkg::ST_AVG_F_WAIT: begin
                if (status.div_done) begin
                    state_next = swr_pm_pkg::ST_AVG_R;
                end
            end
            swr_pm_pkg::ST_AVG_R: state_next = swr_pm_pkg::ST_AVG_R_WAIT;
            swr_pm_pkg::ST_AVG_R_WAIT: begin
                if (status.div_done) begin
                    state_next = swr_pm_pkg::ST_SQ;
                    chan_next  = 1'b0;
                end
            end
            swr_pm_pkg::ST_SQ:  state_next = swr_pm_pkg::ST_MUL;
            swr_pm_pkg::ST_MUL: state_next = swr_pm_pkg::ST_PWR;
            swr_pm_pkg::ST_PWR: begin
                if (!status.pwr_skip) begin
                    state_next = swr_pm_pkg::ST_PWR_WAIT;
                end else if (chan_reg) begin
                    state_next = swr_pm_pkg::ST_SWR_PREP;
                end else begin
                    state_next = swr_pm_pkg::ST_SQ;
                    chan_next  = 1'b1;
                end
            end
            swr_pm_pkg::ST_PWR_WAIT: begin
                if (status.div_done) begin
                    if (chan_reg) begin
                        state_next = swr_pm_pkg::ST_SWR_PREP;
                    end else begin
                        state_next = swr_pm_pkg::ST_SQ;
                        chan_next  = 1'b1;
                    end
                end
            end
            swr_pm_pkg::ST_SWR_PREP: state_next = swr_pm_pkg::ST_SWR;
            swr_pm_pkg::ST_SWR: begin
                state_next = status.swr_skip ? swr_pm_pkg::ST_OUT : swr_pm_pkg::ST_SWR_WAIT;
            end
            swr_pm_pkg::ST_SWR_WAIT: begin
                if (status.div_done) begin
                    state_next = swr_pm_pkg::ST_OUT;
                end
            end
            swr_pm_pkg::ST_OUT: begin
                if (!out_valid_reg || m_tready) begin
                    state_next = swr_pm_pkg::ST_IDLE;
                end
            end
            default: state_next = swr_pm_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        cmd      = '0;
        cmd.chan = chan_reg;
        s_tready = 1'b0;
        case (state_reg)
            swr_pm_pkg::ST_IDLE: begin
                s_tready   = 1'b1;
                cmd.accept = s_tvalid;
            end
            swr_pm_pkg::ST_AVG_F: begin
                cmd.div_start = 1'b1;
                cmd.div_op    = swr_pm_pkg::DOP_AVG_F;
            end
            swr_pm_pkg::ST_AVG_F_WAIT: begin
                cmd.store_avg_f = status.div_done;
            end
            swr_pm_pkg::ST_AVG_R: begin
                cmd.div_start = 1'b1;
                cmd.div_op    = swr_pm_pkg::DOP_AVG_R;
            end
            swr_pm_pkg::ST_AVG_R_WAIT: begin
                // sums are no longer needed once both averages are in
                cmd.store_avg_r = status.div_done;
                cmd.clear_accum = status.div_done;
            end
            swr_pm_pkg::ST_SQ:  cmd.load_sq  = 1'b1;
            swr_pm_pkg::ST_MUL: cmd.load_num = 1'b1;
            swr_pm_pkg::ST_PWR: begin
                cmd.div_op    = swr_pm_pkg::DOP_PWR;
                cmd.div_start = !status.pwr_skip;
                cmd.store_pwr = status.pwr_skip;
            end
            swr_pm_pkg::ST_PWR_WAIT: begin
                cmd.div_op    = swr_pm_pkg::DOP_PWR;
                cmd.store_pwr = status.div_done;
            end
            swr_pm_pkg::ST_SWR_PREP: cmd.load_swr = 1'b1;
            swr_pm_pkg::ST_SWR: begin
                cmd.div_op    = swr_pm_pkg::DOP_SWR;
                cmd.div_start = !status.swr_skip;
                cmd.store_swr = status.swr_skip;
            end
            swr_pm_pkg::ST_SWR_WAIT: begin
                cmd.div_op    = swr_pm_pkg::DOP_SWR;
                cmd.store_swr = status.div_done;
            end
            swr_pm_pkg::ST_OUT: begin
                cmd.load_out = !out_valid_reg || m_tready;
            end
            default: ;
        endcase
    end

    always_comb begin
        if (cmd.load_out) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= swr_pm_pkg::ST_IDLE;
            chan_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            chan_reg      <= chan_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign m_tvalid = out_valid_reg;

endmodule

// ===== rtl/core/swr_pm_checker.sv =====
// Port-level assertions for the SWR power meter, bound to the top level.
module swr_pm_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [swr_pm_pkg::OUT_W-1:0]  m_tdata
);

    localparam int SWR_LSB = 2 * swr_pm_pkg::POW_W;
    localparam int SWR_MSB = SWR_LSB + swr_pm_pkg::SWR_W - 1;
    localparam int PAD_LSB = swr_pm_pkg::OUT_FIELDS_W;
    localparam int PAD_MSB = swr_pm_pkg::OUT_W - 1;

    a_valid_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result word dropped while stalled");

    a_data_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> $stable(m_tdata))
        else $error("result word changed while stalled");

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    a_swr_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[SWR_MSB:SWR_LSB] >= swr_pm_pkg::SWR_MATCHED)
                  && (m_tdata[SWR_MSB:SWR_LSB] <= swr_pm_pkg::SWR_INVALID))
        else $error("SWR outside 100..999");

    a_pad_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[PAD_MSB:PAD_LSB] == '0)
        else $error("padding bits of result word not zero");

endmodule

bind swr_power_meter_core swr_pm_checker u_swr_pm_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// ===== bench/testbench.sv =====
// Self-checking bench for swr_power_meter_core: directed table plus random phases.
module testbench;
    import swr_pm_pkg::*;

    localparam int S_W         = ((2 * SAMPLE_BITS_DEF + 7) / 8) * 8;
    localparam int RAND_ITEMS  = 1950;
    localparam int DRAIN       = 120;
    localparam int LONG_HOLD   = 600;
    localparam int LIMIT       = 1000000;

    typedef struct packed {
        logic [POW_W-1:0] fwd_pw;
        logic [POW_W-1:0] rev_pw;
        logic [SWR_W-1:0] swr;
    } meas_t;

    typedef struct {
        bit               is_cfg;
        cfg_idx_t         idx;
        logic [15:0]      val;
        logic [9:0]       fs;
        logic [9:0]       rs;
        bit               known;
        meas_t            want;
    } row_t;

    logic                  aclk;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [S_W-1:0]        s_tdata;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [OUT_W-1:0]      m_tdata;
    logic                  cfg_we;
    logic [CFG_ADDR_W-1:0] cfg_addr;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    // measurement state and register copies
    logic [ACC_W-1:0]   sum_fwd = '0;
    logic [ACC_W-1:0]   sum_rev = '0;
    logic [CNT_W-1:0]   pairs_in = '0;
    logic [CNT_W-1:0]   reg_count = RST_SAMPLE_COUNT;
    logic [FLOOR_W-1:0] reg_floor = RST_NOISE_FLOOR;
    logic [REF_W-1:0]   reg_ref = RST_REF_POWER;
    logic [CAL_W-1:0]   reg_cal = RST_CAL_READING;

    meas_t meas_due[$];
    int    errors = 0;
    int    burst_left = 0;
    bit    dirty = 0;
    bit    hold_req = 0;

    swr_power_meter_core u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    function automatic logic [POW_W-1:0] chan_power(input logic [ACC_W-1:0] avg);
        bit [63:0] num;
        bit [63:0] den;
        bit [63:0] q;
        if (avg < ACC_W'(reg_floor)) return '0;
        num = 64'(avg) * 64'(avg) * 64'(reg_ref);
        den = 64'(reg_cal) * 64'(reg_cal);
        if (den == 0) return POWER_MAX;
        q = num / den;
        return (q > 64'(POWER_MAX)) ? POWER_MAX : q[POW_W-1:0];
    endfunction

    function automatic logic [SWR_W-1:0] swr_ratio(input logic [ACC_W-1:0] f,
                                                   input logic [ACC_W-1:0] r);
        bit [31:0] s;
        if (f < ACC_W'(reg_floor)) return SWR_INVALID;
        if (r < ACC_W'(reg_floor)) return SWR_MATCHED;
        if (f <= r) return SWR_INVALID;
        s = (32'(SWR_SCALE) * (32'(f) + 32'(r))) / (32'(f) - 32'(r));
        if (s > 32'(SWR_INVALID)) return SWR_INVALID;
        if (s < 32'(SWR_MATCHED)) return SWR_MATCHED;
        return s[SWR_W-1:0];
    endfunction

    // Add one sample pair; return 1 with the measurement when the count is reached.
    function automatic bit accumulate_pair(input logic [9:0] fs, input logic [9:0] rs,
                                           output meas_t m);
        logic [CNT_W-1:0] n;
        logic [ACC_W-1:0] fa;
        logic [ACC_W-1:0] ra;
        m = '0;
        sum_fwd  = sum_fwd + ACC_W'(fs);
        sum_rev  = sum_rev + ACC_W'(rs);
        pairs_in = pairs_in + 1'b1;
        if (reg_count == 0)
            n = CNT_W'(1);
        else if (reg_count > COUNT_MAX)
            n = COUNT_MAX;
        else
            n = reg_count;
        if (pairs_in < n) return 1'b0;
        fa = sum_fwd / ACC_W'(n);
        ra = sum_rev / ACC_W'(n);
        m.fwd_pw = chan_power(fa);
        m.rev_pw = chan_power(ra);
        m.swr    = swr_ratio(fa, ra);
        sum_fwd  = '0;
        sum_rev  = '0;
        pairs_in = '0;
        return 1'b1;
    endfunction

    function automatic row_t cfg_row(input cfg_idx_t idx, input logic [15:0] val);
        row_t r;
        r.is_cfg = 1'b1;
        r.idx    = idx;
        r.val    = val;
        r.fs     = '0;
        r.rs     = '0;
        r.known  = 1'b0;
        r.want   = '0;
        return r;
    endfunction

    function automatic row_t pair_row(input logic [9:0] fs, input logic [9:0] rs);
        row_t r;
        r.is_cfg = 1'b0;
        r.idx    = CFG_SAMPLE_COUNT;
        r.val    = '0;
        r.fs     = fs;
        r.rs     = rs;
        r.known  = 1'b0;
        r.want   = '0;
        return r;
    endfunction

    function automatic row_t known_row(input logic [9:0] fs, input logic [9:0] rs,
                                       input logic [15:0] fp, input logic [15:0] rp,
                                       input logic [9:0] s);
        row_t r;
        r = pair_row(fs, rs);
        r.known  = 1'b1;
        r.want.fwd_pw = fp;
        r.want.rev_pw = rp;
        r.want.swr    = s;
        return r;
    endfunction

    // Offer one word in the current burst; open a new burst with a random gap when due.
    task automatic offer_pair(input logic [9:0] fs, input logic [9:0] rs,
                              input bit known, input meas_t want);
        meas_t m;
        bit    hit;
        int    gap;
        cfg_we <= 1'b0;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(1, 12));
            burst_left = $urandom_range(1, 24);
            if (gap != 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= S_W'({rs, fs});
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        dirty = 1'b1;
        hit = accumulate_pair(fs, rs, m);
        if (known) begin
            hit = 1'b1;
            m   = want;
        end
        if (hit) meas_due.push_back(m);
    endtask

    // Drop valid, wait for every result, then let a trailing sum-only word finish.
    task automatic settle();
        s_tvalid <= 1'b0;
        burst_left = 0;
        while (meas_due.size() != 0) @(posedge aclk);
        repeat (DRAIN) @(posedge aclk);
        dirty = 1'b0;
    endtask

    task automatic write_reg(input cfg_idx_t idx, input logic [15:0] val);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        case (idx)
            CFG_SAMPLE_COUNT: reg_count = val[CNT_W-1:0];
            CFG_NOISE_FLOOR:  reg_floor = val[FLOOR_W-1:0];
            CFG_REF_POWER:    reg_ref   = val[REF_W-1:0];
            CFG_CAL_READING:  reg_cal   = val[CAL_W-1:0];
            default: ;
        endcase
    endtask

    // Result side: own stall pattern, plus one long hold-off on request.
    initial begin : rx_side
        int unsigned mode;
        int unsigned span;
        int unsigned tick;
        bit          hold_done;
        hold_done = 1'b0;
        tick = 0;
        forever begin
            mode = $urandom_range(0, 3);
            span = $urandom_range(20, 200);
            repeat (span) begin
                if (hold_req && !hold_done) begin
                    m_tready <= 1'b0;
                    repeat (LONG_HOLD) @(posedge aclk);
                    hold_done = 1'b1;
                end
                case (mode)
                    0: m_tready <= 1'b1;
                    1: m_tready <= ($urandom_range(0, 3) != 0);
                    2: m_tready <= ($urandom_range(0, 3) == 0);
                    default: m_tready <= ((tick % 4) != 3);
                endcase
                tick++;
                @(posedge aclk);
            end
        end
    end

    always @(posedge aclk) begin : result_check
        meas_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (meas_due.size() == 0) begin
                $display("%0t: unexpected word, expected none, got %h", $time, m_tdata);
                errors++;
            end else begin
                want = meas_due.pop_front();
                if (m_tdata[15:0] !== want.fwd_pw) begin
                    $display("%0t: forward mW expected %0d got %0d",
                             $time, want.fwd_pw, m_tdata[15:0]);
                    errors++;
                end
                if (m_tdata[31:16] !== want.rev_pw) begin
                    $display("%0t: reflected mW expected %0d got %0d",
                             $time, want.rev_pw, m_tdata[31:16]);
                    errors++;
                end
                if (m_tdata[41:32] !== want.swr) begin
                    $display("%0t: swr_hundredths expected %0d got %0d",
                             $time, want.swr, m_tdata[41:32]);
                    errors++;
                end
            end
        end
    end

    initial begin : watchdog
        int cycles;
        cycles = 0;
        while (cycles < LIMIT) begin
            @(posedge aclk);
            cycles++;
        end
        $display("FAIL");
        $finish;
    end

    initial begin : stim
        row_t        rows[$];
        int unsigned phase;
        int unsigned n_items;
        int unsigned sent;
        int unsigned sel;
        int unsigned lvl;
        int unsigned rho;
        int unsigned jit;
        int          fv;
        int          rv;
        logic [15:0] cval;
        logic [15:0] fval;
        logic [15:0] rval;
        logic [15:0] kval;

        aresetn   <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        cfg_we    <= 1'b0;
        cfg_addr  <= CFG_SAMPLE_COUNT;
        cfg_wdata <= '0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        rows.push_back(cfg_row(CFG_SAMPLE_COUNT, 16'd1));
        rows.push_back(known_row(10'd0, 10'd0, 16'd0, 16'd0, SWR_INVALID));
        rows.push_back(known_row(10'd512, 10'd0, 16'd5000, 16'd0, SWR_MATCHED));
        rows.push_back(known_row(10'd512, 10'd512, 16'd5000, 16'd5000, SWR_INVALID));
        rows.push_back(pair_row(10'd1023, 10'd0));
        rows.push_back(pair_row(10'd1023, 10'd1023));
        rows.push_back(known_row(10'd9, 10'd5, 16'd0, 16'd0, SWR_INVALID));
        rows.push_back(pair_row(10'd10, 10'd9));
        rows.push_back(pair_row(10'd300, 10'd100));
        rows.push_back(pair_row(10'd1000, 10'd990));
        rows.push_back(pair_row(10'd1023, 10'd1));
        rows.push_back(pair_row(10'h2AA, 10'h155));
        rows.push_back(pair_row(10'h155, 10'h2AA));
        // zero calibration saturates any channel at or above the floor
        rows.push_back(cfg_row(CFG_CAL_READING, 16'd0));
        rows.push_back(known_row(10'd512, 10'd511, POWER_MAX, POWER_MAX, SWR_INVALID));
        rows.push_back(known_row(10'd5, 10'd0, 16'd0, 16'd0, SWR_INVALID));
        rows.push_back(cfg_row(CFG_CAL_READING, 16'd1));
        rows.push_back(cfg_row(CFG_REF_POWER, 16'hFFFF));
        rows.push_back(cfg_row(CFG_NOISE_FLOOR, 16'd0));
        rows.push_back(known_row(10'd1, 10'd0, POWER_MAX, 16'd0, SWR_MATCHED));
        rows.push_back(cfg_row(CFG_NOISE_FLOOR, 16'd1023));
        rows.push_back(cfg_row(CFG_REF_POWER, 16'd0));
        rows.push_back(cfg_row(CFG_CAL_READING, 16'd1023));
        rows.push_back(known_row(10'd1023, 10'd1022, 16'd0, 16'd0, SWR_MATCHED));
        rows.push_back(cfg_row(CFG_NOISE_FLOOR, 16'd10));
        rows.push_back(cfg_row(CFG_REF_POWER, 16'd5000));
        rows.push_back(cfg_row(CFG_CAL_READING, 16'd512));
        // a count of zero acts as one; high bits beyond the register are dropped
        rows.push_back(cfg_row(CFG_SAMPLE_COUNT, 16'hFF80));
        rows.push_back(pair_row(10'd700, 10'd100));
        // lower the count with three pairs already summed
        rows.push_back(cfg_row(CFG_SAMPLE_COUNT, 16'd4));
        rows.push_back(pair_row(10'd600, 10'd50));
        rows.push_back(pair_row(10'd600, 10'd50));
        rows.push_back(pair_row(10'd600, 10'd50));
        rows.push_back(cfg_row(CFG_SAMPLE_COUNT, 16'd2));
        rows.push_back(pair_row(10'd800, 10'd70));

        foreach (rows[i]) begin
            if (rows[i].is_cfg) begin
                if (dirty) settle();
                write_reg(rows[i].idx, rows[i].val);
            end else begin
                offer_pair(rows[i].fs, rows[i].rs, rows[i].known, rows[i].want);
            end
        end

        sent  = 0;
        phase = 0;
        while (sent < RAND_ITEMS) begin
            case ($urandom_range(0, 9))
                0:       cval = 16'd0;
                1:       cval = 16'd64;
                2:       cval = 16'($urandom_range(65, 127));
                3, 4, 5: cval = 16'($urandom_range(1, 4));
                6, 7, 8: cval = 16'($urandom_range(5, 16));
                default: cval = 16'($urandom_range(17, 63));
            endcase
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5: fval = 16'($urandom_range(0, 40));
                6:       fval = 16'd0;
                7:       fval = 16'd1023;
                8:       fval = 16'($urandom_range(0, 1023));
                default: fval = 16'($urandom_range(100, 400));
            endcase
            case ($urandom_range(0, 7))
                0:       rval = 16'd0;
                1:       rval = 16'hFFFF;
                2, 3:    rval = 16'($urandom_range(0, 65535));
                default: rval = 16'($urandom_range(1000, 10000));
            endcase
            case ($urandom_range(0, 7))
                0:       kval = 16'd0;
                1:       kval = 16'd1;
                2:       kval = 16'd1023;
                default: kval = 16'($urandom_range(200, 900));
            endcase
            if ($urandom_range(0, 3) == 0) begin
                cval = cval | (16'($urandom) & 16'hFF80);
                fval = fval | (16'($urandom) & 16'hFC00);
                kval = kval | (16'($urandom) & 16'hFC00);
            end
            n_items = $urandom_range(16, 120);
            // one phase of single-pair measurements while the receiver holds off
            if (phase == 2) begin
                cval     = 16'd1;
                n_items  = 40;
            end
            if (dirty) settle();
            write_reg(CFG_SAMPLE_COUNT, cval);
            write_reg(CFG_NOISE_FLOOR, fval);
            write_reg(CFG_REF_POWER, rval);
            write_reg(CFG_CAL_READING, kval);
            if (phase == 2) hold_req = 1'b1;

            lvl = $urandom_range(0, 1023);
            rho = $urandom_range(0, 300);
            jit = $urandom_range(0, 20);
            repeat (n_items) begin
                sel = $urandom_range(0, 9);
                if (sel == 0) begin
                    fv = int'($urandom_range(0, 1023));
                    rv = int'($urandom_range(0, 1023));
                end else if (sel == 1) begin
                    fv = ($urandom_range(0, 1) != 0) ? 1023 : 0;
                    rv = ($urandom_range(0, 1) != 0) ? 1023 : 0;
                end else if (sel <= 7) begin
                    fv = int'(lvl) + int'($urandom_range(0, 2 * jit)) - int'(jit);
                    fv = (fv < 0) ? 0 : (fv > 1023) ? 1023 : fv;
                    rv = (fv * int'(rho)) / 256 + int'($urandom_range(0, 2 * jit)) - int'(jit);
                end else begin
                    fv = int'(reg_floor) + int'($urandom_range(0, 6)) - 3;
                    rv = int'(reg_floor) + int'($urandom_range(0, 6)) - 3;
                end
                fv = (fv < 0) ? 0 : (fv > 1023) ? 1023 : fv;
                rv = (rv < 0) ? 0 : (rv > 1023) ? 1023 : rv;
                offer_pair(10'(fv), 10'(rv), 1'b0, '0);
                sent++;
            end
            phase++;
        end

        s_tvalid <= 1'b0;
        while (meas_due.size() != 0) @(posedge aclk);
        repeat (DRAIN) @(posedge aclk);
        if (errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

// ===== swr_power_meter_core.f =====
rtl/core/swr_pm_pkg.sv
rtl/core/swr_pm_div.sv
rtl/core/swr_pm_datapath.sv
rtl/core/swr_pm_ctrl.sv
rtl/core/swr_power_meter_core.sv
rtl/core/swr_pm_checker.sv
bench/testbench.sv
